>>> hw/rtl/khre_pkg.sv
// ----------------------------------------------------------------------------
// khre_pkg
// Shared widths, codes, state type and bit-set helpers for the k-hop
// reachability block with an excluded neighborhood.
// ----------------------------------------------------------------------------
package khre_pkg;

   localparam int NODES = 64;                  // nodes in use, 2 .. 2**IDX_W
   localparam int IDX_W = 6;                   // node index width
   localparam int HOP_W = IDX_W + 1;           // hop limit width, holds NODES
   localparam int SET_W = 2 ** IDX_W;          // width of one node set / row

   localparam logic [SET_W-1:0] NODE_MASK = {SET_W{1'b1}} >> (SET_W - NODES);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WR_RD = 6'b000010,
      ST_WR_WB = 6'b000100,
      ST_INIT  = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_EMIT  = 6'b100000
   } khre_state_type;

   // Clamp a hop limit to NODES.
   function automatic logic [HOP_W-1:0] sat_hops(input logic [HOP_W-1:0] hops);
      logic [HOP_W-1:0] lim;
      lim = HOP_W'(NODES);
      return (hops > lim) ? lim : hops;
   endfunction

   function automatic logic node_ok(input logic [IDX_W-1:0] n);
      return ({1'b0, n} < HOP_W'(NODES));
   endfunction

   // Isolate the lowest set bit of a set.
   function automatic logic [SET_W-1:0] lowest_bit(input logic [SET_W-1:0] v);
      return v & (~v + SET_W'(1));
   endfunction

   // Encode a one-hot set into its index.
   function automatic logic [IDX_W-1:0] onehot_index(input logic [SET_W-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < SET_W; i++) begin
         if (v[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> hw/rtl/k_hop_reach_with_exclusion_top.sv
// ----------------------------------------------------------------------------
// k_hop_reach_with_exclusion_top
// Adjacency bit matrix with edge writes and bounded-walk reach queries that
// drop an excluded neighborhood; answers one node per result word.
// ----------------------------------------------------------------------------
// A request word either writes one edge of the adjacency matrix or runs a
// query, and the block takes no new request until the current one is done.
// An edge write steps through accept, row read and row write back. A
// query gathers two walk sets one after the other with a single matrix read
// port and a single lowest-bit finder: each walk starts with an init step,
// then reads the row of each node it expands (every node is expanded at most once
// per walk, except the start node, which is expanded a second time when a
// walk returns to it) and closes each hop layer in turn; the same
// finder then hands out one result word per cycle in ascending node order
// while the result side does not stall. A walk ends early once a layer adds
// no new node. The matrix reads as all zeros after reset without any
// clearing pass: a flip-flop per row marks rows written since reset.
module k_hop_reach_with_exclusion_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [khre_pkg::IDX_W-1:0] req_edge_from,
   input  logic [khre_pkg::IDX_W-1:0] req_edge_to,
   input  logic                       req_edge_present,
   input  logic [khre_pkg::IDX_W-1:0] req_source_node,
   input  logic [khre_pkg::HOP_W-1:0] req_source_hops,
   input  logic [khre_pkg::IDX_W-1:0] req_avoid_node,
   input  logic [khre_pkg::HOP_W-1:0] req_avoid_hops,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [khre_pkg::IDX_W-1:0] rsp_node_index,
   output logic                       rsp_present,
   output logic                       rsp_last
);
   import khre_pkg::*;

   khre_state_type   state_ff, state_in;
   logic             phase_ff, phase_in;        // 0 reach walk, 1 exclude walk

   logic [IDX_W-1:0] from_ff, from_in;
   logic [IDX_W-1:0] to_ff, to_in;
   logic             edge_bit_ff, edge_bit_in;
   logic [IDX_W-1:0] src_ff, src_in;
   logic [HOP_W-1:0] src_hops_ff, src_hops_in;
   logic [IDX_W-1:0] avoid_ff, avoid_in;
   logic [HOP_W-1:0] avoid_hops_ff, avoid_hops_in;

   logic [SET_W-1:0] frontier_ff, frontier_in;
   logic [SET_W-1:0] gathered_ff, gathered_in;
   logic [SET_W-1:0] accum_ff, accum_in;
   logic [SET_W-1:0] reach_ff, reach_in;
   logic [HOP_W-1:0] step_ff, step_in;
   logic             rd_pend_ff, rd_pend_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic             rsp_present_ff, rsp_present_in;
   logic             rsp_last_ff, rsp_last_in;

   // adjacency memory and per-row written flags
   logic [SET_W-1:0] adj_mem [SET_W];
   logic [SET_W-1:0] row_vld_ff;
   logic [SET_W-1:0] rd_data_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [SET_W-1:0] wr_row;
   logic [SET_W-1:0] row_eff;

   logic [SET_W-1:0] pick_onehot;
   logic [IDX_W-1:0] pick_idx;
   logic [SET_W-1:0] frontier_rest;
   logic [HOP_W-1:0] hops_cur;
   logic [IDX_W-1:0] start_cur;
   logic [SET_W-1:0] layer_next;
   logic [SET_W-1:0] layer_new;
   logic [SET_W-1:0] gathered_upd;
   logic [HOP_W-1:0] step_inc;
   logic [SET_W-1:0] avoid_onehot;
   logic [SET_W-1:0] to_onehot;
   logic             walk_done;
   logic [SET_W-1:0] walk_result;
   logic             out_free;

   assign pick_onehot   = lowest_bit(frontier_ff);
   assign pick_idx      = onehot_index(pick_onehot);
   assign frontier_rest = frontier_ff & ~pick_onehot;
   assign hops_cur      = phase_ff ? avoid_hops_ff : src_hops_ff;
   assign start_cur     = phase_ff ? avoid_ff : src_ff;
   assign layer_next    = accum_ff & NODE_MASK;
   assign layer_new     = layer_next & ~gathered_ff;
   assign gathered_upd  = gathered_ff | layer_next;
   assign step_inc      = step_ff + HOP_W'(1);
   assign avoid_onehot  = SET_W'(1) << avoid_ff;
   assign to_onehot     = SET_W'(1) << to_ff;
   assign row_eff       = rd_vld_ff ? rd_data_ff : '0;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign rd_addr       = (state_ff == ST_SCAN) ? pick_idx : from_ff;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_node_index = rsp_idx_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_last       = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      from_in        = from_ff;
      to_in          = to_ff;
      edge_bit_in    = edge_bit_ff;
      src_in         = src_ff;
      src_hops_in    = src_hops_ff;
      avoid_in       = avoid_ff;
      avoid_hops_in  = avoid_hops_ff;
      frontier_in    = frontier_ff;
      gathered_in    = gathered_ff;
      accum_in       = accum_ff;
      reach_in       = reach_ff;
      step_in        = step_ff;
      rd_pend_in     = rd_pend_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_idx_in     = rsp_idx_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      wr_row         = (row_eff & ~to_onehot) | (edge_bit_ff ? to_onehot : '0);
      walk_done      = 1'b0;
      walk_result    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               from_in       = req_edge_from;
               to_in         = req_edge_to;
               edge_bit_in   = req_edge_present;
               src_in        = req_source_node;
               src_hops_in   = sat_hops(req_source_hops);
               avoid_in      = req_avoid_node;
               avoid_hops_in = sat_hops(req_avoid_hops);
               phase_in      = 1'b0;
               state_in      = (req_kind == KIND_QUERY) ? ST_INIT : ST_WR_RD;
            end
         end
         ST_WR_RD: begin
            state_in = ST_WR_WB;
         end
         ST_WR_WB: begin
            mem_we   = node_ok(from_ff) && node_ok(to_ff);
            state_in = ST_IDLE;
         end
         ST_INIT: begin
            frontier_in = node_ok(start_cur) ? (SET_W'(1) << start_cur) : '0;
            gathered_in = '0;
            accum_in    = '0;
            step_in     = '0;
            rd_pend_in  = 1'b0;
            if (hops_cur == '0) begin
               walk_done = 1'b1;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            accum_in = accum_ff | (rd_pend_ff ? row_eff : '0);
            if (frontier_ff != '0) begin
               // expand the lowest pending node, fold its row next cycle
               frontier_in = frontier_rest;
               rd_pend_in  = 1'b1;
            end else if (rd_pend_ff) begin
               rd_pend_in = 1'b0;
            end else begin
               // close the layer
               frontier_in = layer_new;
               gathered_in = gathered_upd;
               accum_in    = '0;
               step_in     = step_inc;
               if (layer_new == '0 || step_inc == hops_cur) begin
                  walk_done   = 1'b1;
                  walk_result = gathered_upd;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (frontier_ff == '0) begin
                  rsp_idx_in     = '0;
                  rsp_present_in = 1'b0;
                  rsp_last_in    = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  rsp_idx_in     = pick_idx;
                  rsp_present_in = 1'b1;
                  rsp_last_in    = (frontier_rest == '0);
                  frontier_in    = frontier_rest;
                  if (frontier_rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (walk_done) begin
         if (!phase_ff) begin
            reach_in = walk_result;
            phase_in = 1'b1;
            state_in = ST_INIT;
         end else begin
            frontier_in = reach_ff & ~(walk_result | avoid_onehot);
            state_in    = ST_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) begin
            row_vld_ff[from_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      from_ff        <= from_in;
      to_ff          <= to_in;
      edge_bit_ff    <= edge_bit_in;
      src_ff         <= src_in;
      src_hops_ff    <= src_hops_in;
      avoid_ff       <= avoid_in;
      avoid_hops_ff  <= avoid_hops_in;
      frontier_ff    <= frontier_in;
      gathered_ff    <= gathered_in;
      accum_ff       <= accum_in;
      reach_ff       <= reach_in;
      step_ff        <= step_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // adjacency memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         adj_mem[from_ff] <= wr_row;
      end
      rd_data_ff <= adj_mem[rd_addr];
      rd_vld_ff  <= row_vld_ff[rd_addr];
   end

   // an empty answer is always the final word
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_present || rsp_last))
      else $error("empty answer word without last");

   // a query request starts a walk in the next cycle
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == KIND_QUERY) |=> (state_ff == ST_INIT))
      else $error("query accepted but no walk started");

   // the layer count stays below the hop limit while scanning
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (step_ff < hops_cur))
      else $error("walk ran past its hop limit");

   // a row read is pending only during the scan
   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_SCAN))
      else $error("row read pending outside scan");

   // result words of one query come out in ascending node order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=>
         (!rsp_valid || (rsp_node_index > $past(rsp_node_index))))
      else $error("result words out of order");

endmodule

>>> bench/tb_k_hop_reach_with_exclusion_top.sv
// ----------------------------------------------------------------------------
// tb_k_hop_reach_with_exclusion_top
// Self-checking bench for the k-hop reach block with an excluded neighborhood.
// ----------------------------------------------------------------------------
// Edge writes and reach queries go in through the request channel. A
// scoreboard keeps its own copy of the adjacency matrix, works out the
// filtered reach set of every accepted query and checks the answer words in
// order. A directed opening covers the corner cases, then random traffic
// builds a dense subgraph and queries it. Both sides idle at random, except
// during one calm stretch.
// ----------------------------------------------------------------------------
module tb_k_hop_reach_with_exclusion_top;
   timeunit 1ns;
   timeprecision 1ps;

   import khre_pkg::*;

   localparam int ITEMS          = 120;
   localparam int IDLE_PERCENT   = 21;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int MAX_HOPS       = 2 ** HOP_W - 1;

   typedef struct packed {
      logic [IDX_W-1:0] node;
      logic             present;
      logic             last;
   } answer_t;

   class reach_board;
      logic [SET_W-1:0] rows [SET_W];
      answer_t          waiting [$];
      int               mismatches;

      function new();
         foreach (rows[i]) rows[i] = '0;
         mismatches = 0;
      endfunction

      // Nodes reachable from start by walks of 1 .. hops steps.
      function logic [SET_W-1:0] walk_reach(input logic [IDX_W-1:0] start,
                                            input logic [HOP_W-1:0] hops);
         logic [SET_W-1:0] gathered;
         logic [SET_W-1:0] frontier;
         logic [SET_W-1:0] next_layer;
         int               limit;
         int               s;
         int               i;
         gathered = '0;
         limit = (int'(hops) > NODES) ? NODES : int'(hops);
         if (int'(start) >= NODES) begin
            return '0;
         end
         frontier = '0;
         frontier[start] = 1'b1;
         for (s = 0; s < limit; s++) begin
            next_layer = '0;
            for (i = 0; i < SET_W; i++) begin
               if (frontier[i]) begin
                  next_layer |= rows[i];
               end
            end
            next_layer &= NODE_MASK;
            frontier = next_layer & ~gathered;
            gathered |= next_layer;
            if (frontier == '0) begin
               break;
            end
         end
         return gathered;
      endfunction

      function void note_request(input logic kind,
                                 input logic [IDX_W-1:0] row,
                                 input logic [IDX_W-1:0] col,
                                 input logic set_edge,
                                 input logic [IDX_W-1:0] src,
                                 input logic [HOP_W-1:0] src_hops,
                                 input logic [IDX_W-1:0] avoid,
                                 input logic [HOP_W-1:0] avoid_hops);
         logic [SET_W-1:0] reach;
         logic [SET_W-1:0] exclude;
         logic [SET_W-1:0] left;
         int               n;
         if (kind == KIND_WRITE) begin
            if (int'(row) < NODES && int'(col) < NODES) begin
               rows[row][col] = set_edge;
            end
            return;
         end
         reach = walk_reach(src, src_hops);
         exclude = (avoid_hops == '0) ? '0 : walk_reach(avoid, avoid_hops);
         exclude[avoid] = 1'b1;
         left = reach & ~exclude;
         if (left == '0) begin
            waiting.push_back('{node: '0, present: 1'b0, last: 1'b1});
            return;
         end
         for (n = 0; n < SET_W; n++) begin
            if (left[n]) begin
               left[n] = 1'b0;
               waiting.push_back('{node: IDX_W'(n), present: 1'b1, last: (left == '0)});
            end
         end
      endfunction

      function void flag(input string what, input answer_t want, input answer_t got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s: expected node %0d present %0b last %0b, got node %0d present %0b last %0b",
                     $realtime, what, want.node, want.present, want.last,
                     got.node, got.present, got.last);
         end
      endfunction

      function void check_answer(input answer_t got);
         answer_t want;
         if (waiting.size() == 0) begin
            flag("answer word with none pending", '0, got);
            return;
         end
         want = waiting.pop_front();
         // node index carries nothing on the empty answer
         if (got.present !== want.present || got.last !== want.last ||
             (want.present && got.node !== want.node)) begin
            flag("answer word mismatch", want, got);
         end
      endfunction

      function int outstanding();
         return waiting.size();
      endfunction
   endclass

   logic             clock;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   logic             req_kind         = KIND_WRITE;
   logic [IDX_W-1:0] req_edge_from    = '0;
   logic [IDX_W-1:0] req_edge_to      = '0;
   logic             req_edge_present = 1'b0;
   logic [IDX_W-1:0] req_source_node  = '0;
   logic [HOP_W-1:0] req_source_hops  = '0;
   logic [IDX_W-1:0] req_avoid_node   = '0;
   logic [HOP_W-1:0] req_avoid_hops   = '0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   logic [IDX_W-1:0] rsp_node_index;
   logic             rsp_present;
   logic             rsp_last;

   logic             calm             = 1'b0;
   reach_board       board;

   k_hop_reach_with_exclusion_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_edge_from    (req_edge_from),
      .req_edge_to      (req_edge_to),
      .req_edge_present (req_edge_present),
      .req_source_node  (req_source_node),
      .req_source_hops  (req_source_hops),
      .req_avoid_node   (req_avoid_node),
      .req_avoid_hops   (req_avoid_hops),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_node_index   (rsp_node_index),
      .rsp_present      (rsp_present),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Present one request word, hold it until taken, then log it.
   task automatic send_word(input logic kind,
                            input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col,
                            input logic set_edge,
                            input logic [IDX_W-1:0] src,
                            input logic [HOP_W-1:0] src_hops,
                            input logic [IDX_W-1:0] avoid,
                            input logic [HOP_W-1:0] avoid_hops);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_edge_from    <= row;
      req_edge_to      <= col;
      req_edge_present <= set_edge;
      req_source_node  <= src;
      req_source_hops  <= src_hops;
      req_avoid_node   <= avoid;
      req_avoid_hops   <= avoid_hops;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      board.note_request(kind, row, col, set_edge, src, src_hops, avoid, avoid_hops);
   endtask

   // Query fields ride along with junk to show they are ignored.
   task automatic write_edge(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input logic set_edge);
      send_word(KIND_WRITE, row, col, set_edge, IDX_W'($urandom), HOP_W'($urandom),
                IDX_W'($urandom), HOP_W'($urandom));
   endtask

   task automatic run_query(input logic [IDX_W-1:0] src, input logic [HOP_W-1:0] src_hops,
                            input logic [IDX_W-1:0] avoid, input logic [HOP_W-1:0] avoid_hops);
      send_word(KIND_QUERY, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom),
                src, src_hops, avoid, avoid_hops);
   endtask

   // Mostly short walks, some up to NODES, some past it to hit saturation.
   function automatic logic [HOP_W-1:0] random_hops();
      int roll;
      roll = $urandom_range(9);
      if (roll < 6) begin
         return HOP_W'($urandom_range(4));
      end
      if (roll < 8) begin
         return HOP_W'($urandom_range(NODES, 5));
      end
      return HOP_W'($urandom_range(MAX_HOPS, NODES + 1));
   endfunction

   function automatic logic [IDX_W-1:0] random_node();
      if ($urandom_range(3) != 0) begin
         return IDX_W'($urandom_range(15));
      end
      return IDX_W'($urandom);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            board.check_answer('{node: rsp_node_index, present: rsp_present, last: rsp_last});
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [IDX_W-1:0] src;
      logic [IDX_W-1:0] avoid;
      logic [HOP_W-1:0] avoid_hops;
      int               n;
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty matrix answers empty
      run_query(6'd0, 7'd5, 6'd1, 7'd0);
      write_edge(6'd0, 6'd1, 1'b1);
      write_edge(6'd1, 6'd2, 1'b1);
      write_edge(6'd2, 6'd3, 1'b1);
      write_edge(6'd3, 6'd0, 1'b1);
      write_edge(6'd63, 6'd0, 1'b1);
      write_edge(6'd5, 6'd5, 1'b1);
      write_edge(6'd62, 6'd63, 1'b1);
      run_query(6'd0, 7'd0, 6'd63, 7'd0);
      run_query(6'd0, 7'd1, 6'd63, 7'd0);
      run_query(6'd0, 7'd127, 6'd63, 7'd0);
      run_query(6'd0, 7'd64, 6'd2, 7'd1);
      run_query(6'd0, 7'd4, 6'd0, 7'd0);
      run_query(6'd5, 7'd3, 6'd63, 7'd64);
      run_query(6'd62, 7'd2, 6'd5, 7'd127);
      run_query(6'd63, 7'd64, 6'd0, 7'd127);
      write_edge(6'd3, 6'd0, 1'b0);
      run_query(6'd0, 7'd64, 6'd63, 7'd0);
      write_edge(6'd63, 6'd63, 1'b1);
      run_query(6'd63, 7'd1, 6'd0, 7'd0);
      run_query(6'd63, 7'd65, 6'd63, 7'd0);

      // hold off until the block has answered everything
      req_valid <= 1'b0;
      while (board.outstanding() != 0) begin
         @(posedge clock);
      end

      for (n = 0; n < ITEMS; n++) begin
         if (n == 40) begin
            calm <= 1'b1;
         end
         if (n == 75) begin
            calm <= 1'b0;
         end
         if ($urandom_range(99) < 50) begin
            // most edges land in a small subgraph so walks go deep
            if ($urandom_range(9) < 7) begin
               write_edge(IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
                          $urandom_range(99) < 75);
            end else begin
               write_edge(IDX_W'($urandom), IDX_W'($urandom), $urandom_range(99) < 75);
            end
         end else begin
            src = random_node();
            avoid = random_node();
            avoid_hops = ($urandom_range(9) < 3) ? '0 : random_hops();
            run_query(src, random_hops(), avoid, avoid_hops);
         end
      end
      req_valid <= 1'b0;

      while (board.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
